// ===== rtl/swr_pkg.sv =====
// ----------------------------------------------------------------------------
// swr_pkg
// Shared types and constants for the streaming word-replace block.
// ----------------------------------------------------------------------------
package swr_pkg;

  localparam int BYTE_W      = 8;
  localparam int WORD_W      = 64;
  localparam int CNT_W       = 4;   // holds a count of 0..8 bytes
  localparam int POS_W       = 3;   // match position, 0..7
  localparam int PATTERN_MAX = 8;
  localparam int REPL_CAP    = 8;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_PATTERN_BYTES      = 2'd0,
    REG_PATTERN_LENGTH     = 2'd1,
    REG_REPLACEMENT_BYTES  = 2'd2,
    REG_REPLACEMENT_LENGTH = 2'd3
  } cfg_reg_t;

  // Configuration register contents
  typedef struct packed {
    logic [WORD_W-1:0] pattern_bytes;
    logic [CNT_W-1:0]  pattern_length;
    logic [WORD_W-1:0] replacement_bytes;
    logic [CNT_W-1:0]  replacement_length;
  } cfg_t;

  // Emission command: count bytes from pattern or replacement, then an
  // optional tail byte
  typedef struct packed {
    logic              use_repl;
    logic [CNT_W-1:0]  count;
    logic              tail_en;
    logic [BYTE_W-1:0] tail_byte;
  } cmd_t;

endpackage

// ===== rtl/swr_front.sv =====
// ----------------------------------------------------------------------------
// swr_front
// Accepts input items, tracks the partial match and classifies each item
// into an emission command for the back end.
// ----------------------------------------------------------------------------
module swr_front import swr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  cfg_t              cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [BYTE_W-1:0] in_data_byte,
  input  logic              in_end_marker,
  input  logic              q_full,
  output logic              q_push,
  output cmd_t              q_cmd
);

  logic [POS_W-1:0]  match_pos_r, match_pos_nxt;
  logic [CNT_W-1:0]  plen, rlen;
  logic [BYTE_W-1:0] pat_byte;
  logic              accept;
  logic              emit;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // Saturate the lengths to their legal ranges
  always_comb begin
    plen = cfg.pattern_length;
    if (plen == '0) begin
      plen = CNT_W'(1);
    end else if (plen > CNT_W'(PATTERN_MAX)) begin
      plen = CNT_W'(PATTERN_MAX);
    end
    rlen = cfg.replacement_length;
    if (rlen > CNT_W'(REPL_CAP)) begin
      rlen = CNT_W'(REPL_CAP);
    end
  end

  assign pat_byte = cfg.pattern_bytes[{match_pos_r, 3'b000} +: BYTE_W];

  // Classify the item
  always_comb begin
    q_cmd.use_repl  = 1'b0;
    q_cmd.count     = CNT_W'(match_pos_r);
    q_cmd.tail_en   = 1'b0;
    q_cmd.tail_byte = in_data_byte;
    emit            = 1'b0;
    match_pos_nxt   = '0;
    if (in_end_marker) begin
      // flush the held prefix, if any
      emit = (match_pos_r != '0);
    end else if (in_data_byte == pat_byte) begin
      if ((CNT_W'(match_pos_r) + CNT_W'(1)) >= plen) begin
        q_cmd.use_repl = 1'b1;
        q_cmd.count    = rlen;
        emit           = (rlen != '0);
      end else begin
        match_pos_nxt = match_pos_r + POS_W'(1);
      end
    end else begin
      // mismatch: held prefix then the offending byte
      q_cmd.tail_en = 1'b1;
      emit          = 1'b1;
    end
  end

  assign q_push = accept && emit;

  // Match position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_pos_r <= '0;
    end else if (accept) begin
      match_pos_r <= match_pos_nxt;
    end
  end

endmodule

// ===== rtl/swr_queue.sv =====
// ----------------------------------------------------------------------------
// swr_queue
// Short command queue between the front and the back end.
// ----------------------------------------------------------------------------
module swr_queue import swr_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output logic full,
  output logic head_valid,
  output cmd_t head_cmd
);

  cmd_t              entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              do_pop;

  assign full       = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_cmd   = entry_r[rd_ptr_r];
  assign do_pop     = pop && head_valid;

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
      end
      if (push && !do_pop) begin
        count_r <= count_r + QCNT_W'(1);
      end else if (do_pop && !push) begin
        count_r <= count_r - QCNT_W'(1);
      end
    end
  end

endmodule

// ===== rtl/swr_back.sv =====
// ----------------------------------------------------------------------------
// swr_back
// Walks the head command one byte per cycle into the output register while out_ready does not stall it.
// ----------------------------------------------------------------------------
module swr_back import swr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  cfg_t              cfg,
  input  logic              head_valid,
  input  cmd_t              head_cmd,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [BYTE_W-1:0] out_byte,
  output logic              out_last_of_run
);

  logic [POS_W-1:0]  idx_r;
  logic              out_valid_r;
  logic [BYTE_W-1:0] out_byte_r;
  logic              out_last_r;
  logic [WORD_W-1:0] src;
  logic [CNT_W-1:0]  total;
  logic [BYTE_W-1:0] cur_byte;
  logic              cur_last;
  logic              advance;

  assign src   = head_cmd.use_repl ? cfg.replacement_bytes : cfg.pattern_bytes;
  assign total = head_cmd.count + CNT_W'(head_cmd.tail_en);

  // Byte at the current index: source bytes first, then the tail
  always_comb begin
    if (CNT_W'(idx_r) < head_cmd.count) begin
      cur_byte = src[{idx_r, 3'b000} +: BYTE_W];
    end else begin
      cur_byte = head_cmd.tail_byte;
    end
    cur_last = ((CNT_W'(idx_r) + CNT_W'(1)) == total);
  end

  assign advance = head_valid && (!out_valid_r || out_ready);
  assign pop     = advance && cur_last;

  // Byte index within the command and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (advance) begin
        idx_r       <= cur_last ? '0 : idx_r + POS_W'(1);
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (advance) begin
      out_byte_r <= cur_byte;
      out_last_r <= cur_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_byte        = out_byte_r;
  assign out_last_of_run = out_last_r;

endmodule

// ===== rtl/stream_word_replace.sv =====
// ----------------------------------------------------------------------------
// stream_word_replace
// Streaming find-and-replace of a pattern of up to eight bytes on a byte
// stream, with configuration registers and a front/back split.
// ----------------------------------------------------------------------------
// The first result of an item passes through the command queue and then the output register.
// Throughput: one item per cycle while each item yields at most one result and
// out_ready does not stall the output; an item that yields several results holds
// the back end until all are emitted, and the two-entry command queue stalls the input once it fills.
// Reset: synchronous, active low; clears match state, queue and output valid,
// and loads the register reset values.
module stream_word_replace import swr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [WORD_W-1:0] cfg_wdata,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [BYTE_W-1:0] in_data_byte,
  input  logic              in_end_marker,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [BYTE_W-1:0] out_byte,
  output logic              out_last_of_run
);

  cfg_t cfg_r;
  logic q_full, q_push, q_pop, q_head_valid;
  cmd_t q_cmd, q_head_cmd;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pattern_bytes      <= '0;
      cfg_r.pattern_length     <= CNT_W'(1);
      cfg_r.replacement_bytes  <= '0;
      cfg_r.replacement_length <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PATTERN_BYTES:      cfg_r.pattern_bytes      <= cfg_wdata;
        REG_PATTERN_LENGTH:     cfg_r.pattern_length     <= cfg_wdata[CNT_W-1:0];
        REG_REPLACEMENT_BYTES:  cfg_r.replacement_bytes  <= cfg_wdata;
        REG_REPLACEMENT_LENGTH: cfg_r.replacement_length <= cfg_wdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  swr_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data_byte  (in_data_byte),
    .in_end_marker (in_end_marker),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_cmd         (q_cmd)
  );

  swr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (q_cmd),
    .pop        (q_pop),
    .full       (q_full),
    .head_valid (q_head_valid),
    .head_cmd   (q_head_cmd)
  );

  swr_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .head_valid      (q_head_valid),
    .head_cmd        (q_head_cmd),
    .pop             (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_last_of_run (out_last_of_run)
  );

endmodule
